// ===== design/kca_pkg.sv =====
// Shared types, key table constants and decode functions for the autorepeat engine.
package kca_pkg;

   localparam int unsigned NumKeys = 13;

   localparam logic [15:0] MaskUp       = 16'h4000;
   localparam logic [15:0] MaskDown     = 16'h0400;
   localparam logic [15:0] MaskLeft     = 16'h0100;
   localparam logic [15:0] MaskRight    = 16'h0200;
   localparam logic [15:0] MaskSet      = 16'h8000;
   localparam logic [1:0]  MaskShootFull = 2'b11;
   localparam logic [1:0]  MaskShootOnly = 2'b10;
   localparam logic [1:0]  MaskShootHalf = 2'b01;
   localparam logic [15:0] MaskZoomIn   = 16'h0010;
   localparam logic [15:0] MaskZoomOut  = 16'h0020;
   localparam logic [15:0] MaskMenu     = 16'h2000;
   localparam logic [15:0] MaskDisplay  = 16'h1000;
   localparam logic [15:0] MaskPrint    = 16'h0800;

   localparam logic [15:0] FirstDelayReset  = 16'd500;
   localparam logic [15:0] RepeatDelayReset = 16'd175;

   localparam logic MODE_SCAN   = 1'b0;
   localparam logic MODE_FORGET = 1'b1;

   localparam logic CSR_FIRST_DELAY  = 1'b0;
   localparam logic CSR_REPEAT_DELAY = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [15:0] main_bits;
      logic [1:0]  shutter_bits;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [3:0] event_key;
      logic       is_repeat;
      logic [3:0] held_key;
   } rsp_type;

   // Bit k set when table key k+1 is pressed (all its mask bits low).
   function automatic logic [NumKeys-1:0] pressed_vec(input logic [15:0] mainv,
                                                      input logic [1:0] shut);
      logic [NumKeys-1:0] v;
      v[0]  = (mainv & MaskUp) == '0;
      v[1]  = (mainv & MaskDown) == '0;
      v[2]  = (mainv & MaskLeft) == '0;
      v[3]  = (mainv & MaskRight) == '0;
      v[4]  = (mainv & MaskSet) == '0;
      v[5]  = (shut & MaskShootFull) == '0;
      v[6]  = (shut & MaskShootOnly) == '0;
      v[7]  = (shut & MaskShootHalf) == '0;
      v[8]  = (mainv & MaskZoomIn) == '0;
      v[9]  = (mainv & MaskZoomOut) == '0;
      v[10] = (mainv & MaskMenu) == '0;
      v[11] = (mainv & MaskDisplay) == '0;
      v[12] = (mainv & MaskPrint) == '0;
      return v;
   endfunction

   // Table position of the lowest set bit, 0 when none.
   function automatic logic [3:0] first_key(input logic [NumKeys-1:0] v);
      logic [3:0] pos;
      pos = 4'd0;
      for (int k = NumKeys - 1; k >= 0; k--) begin
         if (v[k]) begin
            pos = 4'(k + 1);
         end
      end
      return pos;
   endfunction

endpackage

// ===== design/key_click_autorepeat_engine.sv =====
// Top level: input register, scan/repeat logic and result register.
// Takes one scan or forget beat per clock. A beat is captured in an input
// register, then the key table decode, click priority pick and wrapping
// hold-time compare run and the result lands in the output register:
// throughput is one beat per cycle while rsp_ready is high. Delay registers
// are written through the csr_ port (index 0 first delay, index 1 repeat
// delay), which is always ready and should be used only while no beat is in
// flight.
module key_click_autorepeat_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [15:0] req_main_bits,
   input  logic [1:0]  req_shutter_bits,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_event_key,
   output logic        rsp_is_repeat,
   output logic [3:0]  rsp_held_key,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   logic             in_valid_ff, in_valid_in;
   kca_pkg::req_type in_item_ff;
   logic             out_valid_ff, out_valid_in;
   kca_pkg::rsp_type out_data_ff;
   kca_pkg::rsp_type result;
   logic             advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   kca_state u_state (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (in_item_ff),
      .csr_we    (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .result    (result)
   );

   always_comb begin
      in_valid_in  = req_valid || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= '{mode: req_mode, main_bits: req_main_bits,
                         shutter_bits: req_shutter_bits, now_ms: req_now_ms};
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_event_key = out_data_ff.event_key;
   assign rsp_is_repeat = out_data_ff.is_repeat;
   assign rsp_held_key  = out_data_ff.held_key;

endmodule

// ===== design/kca_state.sv =====
// Key scan history, click detection and autorepeat timing for one scan or forget beat.
module kca_state (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  kca_pkg::req_type  item,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [15:0]       csr_data,
   output kca_pkg::rsp_type  result
);

   logic [15:0] first_delay_ff, first_delay_in;
   logic [15:0] repeat_delay_ff, repeat_delay_in;
   logic [15:0] cur_main_ff, cur_main_in;
   logic [1:0]  cur_shut_ff, cur_shut_in;
   logic [3:0]  rem_key_ff, rem_key_in;
   logic        repeating_ff, repeating_in;
   logic [31:0] last_time_ff, last_time_in;

   logic [kca_pkg::NumKeys-1:0] prev_pressed;
   logic [kca_pkg::NumKeys-1:0] now_pressed;
   logic [15:0]                 now_pressed_wide;
   logic [3:0]                  clicked;
   logic [3:0]                  rem_idx;
   logic                        rem_held;
   logic [31:0]                 diff;
   logic [15:0]                 delay;
   logic                        due;
   logic                        scan;

   assign scan = item.mode == kca_pkg::MODE_SCAN;

   always_comb begin
      // previous scan is the stored current one
      prev_pressed     = kca_pkg::pressed_vec(cur_main_ff, cur_shut_ff);
      now_pressed      = scan ? kca_pkg::pressed_vec(item.main_bits, item.shutter_bits)
                              : prev_pressed;
      now_pressed_wide = {{(16 - kca_pkg::NumKeys){1'b0}}, now_pressed};
      clicked          = kca_pkg::first_key(~prev_pressed & now_pressed);
      rem_idx          = rem_key_ff - 4'd1;
      rem_held         = (rem_key_ff != 4'd0) && now_pressed_wide[rem_idx];
      diff             = item.now_ms - last_time_ff;
      delay            = repeating_ff ? repeat_delay_ff : first_delay_ff;
      due              = !diff[31] && (diff > {16'd0, delay});
   end

   always_comb begin
      cur_main_in      = cur_main_ff;
      cur_shut_in      = cur_shut_ff;
      rem_key_in       = rem_key_ff;
      repeating_in     = repeating_ff;
      last_time_in     = last_time_ff;
      result.event_key = 4'd0;
      result.is_repeat = 1'b0;
      result.held_key  = kca_pkg::first_key(now_pressed);
      if (!scan) begin
         rem_key_in = 4'd0;
      end else begin
         cur_main_in = item.main_bits;
         cur_shut_in = item.shutter_bits;
         if (clicked != 4'd0) begin
            rem_key_in       = clicked;
            repeating_in     = 1'b0;
            last_time_in     = item.now_ms;
            result.event_key = clicked;
         end else if (rem_held) begin
            if (due) begin
               repeating_in     = 1'b1;
               last_time_in     = item.now_ms;
               result.event_key = rem_key_ff;
               result.is_repeat = 1'b1;
            end
         end else begin
            rem_key_in = 4'd0;
         end
      end
   end

   always_comb begin
      first_delay_in  = first_delay_ff;
      repeat_delay_in = repeat_delay_ff;
      if (csr_we) begin
         unique case (csr_index)
            kca_pkg::CSR_FIRST_DELAY:  first_delay_in  = csr_data;
            kca_pkg::CSR_REPEAT_DELAY: repeat_delay_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_delay_ff  <= kca_pkg::FirstDelayReset;
         repeat_delay_ff <= kca_pkg::RepeatDelayReset;
         cur_main_ff     <= '1;
         cur_shut_ff     <= '1;
         rem_key_ff      <= 4'd0;
         repeating_ff    <= 1'b0;
         last_time_ff    <= 32'd0;
      end else begin
         first_delay_ff  <= first_delay_in;
         repeat_delay_ff <= repeat_delay_in;
         if (step) begin
            cur_main_ff  <= cur_main_in;
            cur_shut_ff  <= cur_shut_in;
            rem_key_ff   <= rem_key_in;
            repeating_ff <= repeating_in;
            last_time_ff <= last_time_in;
         end
      end
   end

endmodule
